[sv/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: consequent not seen with antecedent");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: consequent not seen one cycle later");

`endif

[sv/i2crts_pkg.sv]
// Types and codes of the I2C register transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2crts_pkg;

	typedef enum logic [2:0] {
		OP_BEGIN      = 3'd0,
		OP_START_SENT = 3'd1,
		OP_ADDR_SENT  = 3'd2,
		OP_TX_EMPTY   = 3'd3,
		OP_RX_BYTE    = 3'd4,
		OP_BUS_ERROR  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_ADDR    = 3'd1,
		ACT_CLRADDR = 3'd2,
		ACT_TX      = 3'd3,
		ACT_RESTART = 3'd4,
		ACT_RX      = 3'd5,
		ACT_STOP    = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WRITE = 2'd1,
		PH_READ  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       is_read;
		logic [6:0] slave_address;
		logic [7:0] register_address;
		logic       register_bytes;
		logic [7:0] data_bytes;
		logic [7:0] tx_byte;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] out_byte;
		logic       ack_enable;
		logic       send_stop;
		logic       tx_taken;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       status;
		logic       finished;
	} result_t;

	// reg_left runs -1..1; -1 in a read marks the data phase
	typedef struct packed {
		phase_t            phase;
		logic              read_mode;
		logic [6:0]        target_address;
		logic [7:0]        reg_byte;
		logic signed [1:0] reg_left;
		logic [7:0]        data_left;
		logic              ack_level;
		logic              success_flag;
	} seq_state_t;

endpackage
`default_nettype wire

[sv/i2c_register_transfer_sequencer_core.sv]
// Top level of the I2C register transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Decides the next byte-engine action for each bus event item. One item is
// taken per cycle. The item waits in an input register; the decision and the
// transfer state update happen in the cycle it moves into the result register,
// from which the result is taken. The result register parts the two channels,
// so a new item is accepted while a result waits, and a stall on the result
// side holds the input side only once both registers are full.
module i2c_register_transfer_sequencer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic       is_read,
	input  logic [6:0] slave_address,
	input  logic [7:0] register_address,
	input  logic       register_bytes,
	input  logic [7:0] data_bytes,
	input  logic [7:0] tx_byte,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] action,
	output logic [7:0] out_byte,
	output logic       ack_enable,
	output logic       send_stop,
	output logic       tx_taken,
	output logic       rx_valid,
	output logic [7:0] rx_data,
	output logic       status,
	output logic       finished
);
	import i2crts_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	result_t    res_q;
	logic       out_valid_q;
	seq_state_t st_q;
	seq_state_t st_next;
	result_t    res_next;
	logic       advance;
	logic       in_take;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	i2crts_decide u_decide (
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '{phase: PH_IDLE, read_mode: 1'b0, target_address: 7'd0,
				reg_byte: 8'd0, reg_left: 2'sd0, data_left: 8'd0,
				ack_level: 1'b1, success_flag: 1'b0};
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				st_q        <= st_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{opcode: opcode, is_read: is_read, slave_address: slave_address,
				register_address: register_address, register_bytes: register_bytes,
				data_bytes: data_bytes, tx_byte: tx_byte, rx_byte: rx_byte};
		end
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = res_q.action;
	assign out_byte   = res_q.out_byte;
	assign ack_enable = res_q.ack_enable;
	assign send_stop  = res_q.send_stop;
	assign tx_taken   = res_q.tx_taken;
	assign rx_valid   = res_q.rx_valid;
	assign rx_data    = res_q.rx_data;
	assign status     = res_q.status;
	assign finished   = res_q.finished;

endmodule
`default_nettype wire

[sv/i2crts_decide.sv]
// Next-action decision for one bus event: next state and result item.
`timescale 1ns / 1ps
`default_nettype none
module i2crts_decide (
	input  i2crts_pkg::seq_state_t st,
	input  i2crts_pkg::item_t      item,
	output i2crts_pkg::seq_state_t st_next,
	output i2crts_pkg::result_t    res
);
	import i2crts_pkg::*;

	logic [2:0] op;
	assign op = item.opcode;

	always_comb begin
		st_next        = st;
		res            = '0;
		res.action     = ACT_NONE;
		if (op == OP_BEGIN) begin
			st_next.read_mode      = item.is_read;
			st_next.target_address = item.slave_address;
			st_next.reg_byte       = item.register_address;
			st_next.reg_left       = {1'b0, item.register_bytes};
			st_next.data_left      = item.data_bytes;
			st_next.ack_level      = 1'b1;
			st_next.success_flag   = 1'b0;
			st_next.phase          = item.is_read ? PH_READ : PH_WRITE;
		end else if (st.phase != PH_IDLE && op == OP_BUS_ERROR) begin
			res.finished  = 1'b1;
			st_next.phase = PH_IDLE;
		end else begin
			unique case (st.phase)
				PH_WRITE: begin
					if (op == OP_START_SENT) begin
						res.action   = ACT_ADDR;
						res.out_byte = {st.target_address, 1'b0};
					end else if (op == OP_ADDR_SENT) begin
						res.action = ACT_CLRADDR;
					end else if (op == OP_TX_EMPTY) begin
						if (st.reg_left == 2'sd1) begin
							res.action       = ACT_TX;
							res.out_byte     = st.reg_byte;
							st_next.reg_left = st.reg_left - 2'sd1;
						end else if (st.data_left != 8'd0) begin
							res.action        = ACT_TX;
							res.out_byte      = item.tx_byte;
							res.tx_taken      = 1'b1;
							st_next.data_left = st.data_left - 8'd1;
							if (st.data_left == 8'd1) begin
								st_next.success_flag = 1'b1;
							end
						end else begin
							res.action    = ACT_STOP;
							res.send_stop = 1'b1;
							res.finished  = 1'b1;
							st_next.phase = PH_IDLE;
						end
					end
				end
				PH_READ: begin
					if (!st.reg_left[1]) begin
						// register phase: address with write bit, register byte, restart
						if (op == OP_START_SENT) begin
							res.action   = ACT_ADDR;
							res.out_byte = {st.target_address, 1'b0};
						end else if (op == OP_ADDR_SENT) begin
							res.action = ACT_CLRADDR;
						end else if (op == OP_TX_EMPTY) begin
							if (st.reg_left == 2'sd1) begin
								res.action   = ACT_TX;
								res.out_byte = st.reg_byte;
							end else begin
								res.action = ACT_RESTART;
							end
							st_next.reg_left = st.reg_left - 2'sd1;
						end
					end else begin
						if (op == OP_START_SENT) begin
							res.action   = ACT_ADDR;
							res.out_byte = {st.target_address, 1'b1};
						end else if (op == OP_ADDR_SENT) begin
							if (st.data_left == 8'd1 || st.data_left == 8'd2) begin
								st_next.ack_level = 1'b0;
							end
							res.action = ACT_CLRADDR;
						end else if (op == OP_RX_BYTE && st.data_left != 8'd0) begin
							if (st.data_left == 8'd3) begin
								st_next.ack_level = 1'b0;
							end
							res.action        = ACT_RX;
							res.rx_valid      = 1'b1;
							res.rx_data       = item.rx_byte;
							st_next.data_left = st.data_left - 8'd1;
							if (st.data_left == 8'd1) begin
								// last byte: stop, flag success, restore ack
								res.send_stop        = 1'b1;
								res.finished         = 1'b1;
								st_next.success_flag = 1'b1;
								st_next.ack_level    = 1'b1;
								st_next.phase        = PH_IDLE;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.ack_enable = st_next.ack_level;
		res.status     = st_next.success_flag;
	end

endmodule
`default_nettype wire

[sv/i2crts_checker.sv]
// Port-level assertions of the I2C register transfer sequencer, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module i2crts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] action,
	input logic [7:0] out_byte,
	input logic       send_stop,
	input logic       tx_taken,
	input logic       rx_valid,
	input logic       finished
);
	import i2crts_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(action) && $stable(out_byte))
	`ASSERT_SAME(a_stop_ends, clk, arst_n, out_valid && send_stop, finished && (action == ACT_STOP || action == ACT_RX))
	`ASSERT_SAME(a_taken_tx, clk, arst_n, out_valid && tx_taken, action == ACT_TX && !finished)
	`ASSERT_SAME(a_rx_action, clk, arst_n, out_valid && rx_valid, action == ACT_RX && !tx_taken)

endmodule

bind i2c_register_transfer_sequencer_core i2crts_checker u_i2crts_checker (.*);
`default_nettype wire

[verif/tb_i2c_register_transfer_sequencer_core.sv]
// Self-checking testbench for the I2C register transfer sequencer core.
`timescale 1ns / 1ps
module tb_i2c_register_transfer_sequencer_core;
	import i2crts_pkg::*;

	// opcodes that the block leaves alone
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int TARGET_ITEMS = 1050;
	localparam int CALM_AFTER = 900;
	localparam int PRINT_CAP = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] opcode = OP_BEGIN;
	logic       is_read = 1'b0;
	logic [6:0] slave_address = '0;
	logic [7:0] register_address = '0;
	logic       register_bytes = 1'b0;
	logic [7:0] data_bytes = '0;
	logic [7:0] tx_byte = '0;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] action;
	logic [7:0] out_byte;
	logic       ack_enable;
	logic       send_stop;
	logic       tx_taken;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic       status;
	logic       finished;

	i2c_register_transfer_sequencer_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .is_read(is_read), .slave_address(slave_address),
		.register_address(register_address), .register_bytes(register_bytes),
		.data_bytes(data_bytes), .tx_byte(tx_byte), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .out_byte(out_byte), .ack_enable(ack_enable),
		.send_stop(send_stop), .tx_taken(tx_taken), .rx_valid(rx_valid),
		.rx_data(rx_data), .status(status), .finished(finished)
	);

	always #6 clk = ~clk;

	class transfer_scoreboard;
		phase_t            stage;
		bit                reading;
		bit [6:0]          dev_addr;
		bit [7:0]          reg_addr;
		bit signed [1:0]   reg_pending;
		bit [7:0]          bytes_left;
		bit                ack_on;
		bit                done_ok;
		result_t           pending_q[$];
		int                errors;
		int                items_noted;
		int                results_seen;
		int                stops;
		int                bus_errors;

		function new();
			stage = PH_IDLE;
			reading = 1'b0;
			dev_addr = '0;
			reg_addr = '0;
			reg_pending = 2'sd0;
			bytes_left = '0;
			ack_on = 1'b1;
			done_ok = 1'b0;
		endfunction

		// Work out the engine action for one bus event and queue it.
		function void note_item(item_t it);
			result_t r;
			r = '0;
			r.action = ACT_NONE;
			items_noted++;
			if (it.opcode == OP_BEGIN) begin
				reading = it.is_read;
				dev_addr = it.slave_address;
				reg_addr = it.register_address;
				reg_pending = it.register_bytes ? 2'sd1 : 2'sd0;
				bytes_left = it.data_bytes;
				ack_on = 1'b1;
				done_ok = 1'b0;
				stage = it.is_read ? PH_READ : PH_WRITE;
			end else if (stage != PH_IDLE && it.opcode == OP_BUS_ERROR) begin
				r.finished = 1'b1;
				stage = PH_IDLE;
				bus_errors++;
			end else if (stage == PH_WRITE) begin
				if (it.opcode == OP_START_SENT) begin
					r.action = ACT_ADDR;
					r.out_byte = {dev_addr, 1'b0};
				end else if (it.opcode == OP_ADDR_SENT) begin
					r.action = ACT_CLRADDR;
				end else if (it.opcode == OP_TX_EMPTY) begin
					if (reg_pending > 2'sd0) begin
						r.action = ACT_TX;
						r.out_byte = reg_addr;
						reg_pending = reg_pending - 2'sd1;
					end else if (bytes_left != 0) begin
						r.action = ACT_TX;
						r.out_byte = it.tx_byte;
						r.tx_taken = 1'b1;
						bytes_left = bytes_left - 8'd1;
						if (bytes_left == 0)
							done_ok = 1'b1;
					end else begin
						r.action = ACT_STOP;
						r.send_stop = 1'b1;
						r.finished = 1'b1;
						stage = PH_IDLE;
						stops++;
					end
				end
			end else if (stage == PH_READ) begin
				if (reg_pending >= 2'sd0) begin
					// register phase: address with write bit, register byte, restart
					if (it.opcode == OP_START_SENT) begin
						r.action = ACT_ADDR;
						r.out_byte = {dev_addr, 1'b0};
					end else if (it.opcode == OP_ADDR_SENT) begin
						r.action = ACT_CLRADDR;
					end else if (it.opcode == OP_TX_EMPTY) begin
						if (reg_pending > 2'sd0) begin
							r.action = ACT_TX;
							r.out_byte = reg_addr;
						end else begin
							r.action = ACT_RESTART;
						end
						reg_pending = reg_pending - 2'sd1;
					end
				end else begin
					if (it.opcode == OP_START_SENT) begin
						r.action = ACT_ADDR;
						r.out_byte = {dev_addr, 1'b1};
					end else if (it.opcode == OP_ADDR_SENT) begin
						if (bytes_left == 8'd1 || bytes_left == 8'd2)
							ack_on = 1'b0;
						r.action = ACT_CLRADDR;
					end else if (it.opcode == OP_RX_BYTE && bytes_left != 0) begin
						if (bytes_left == 8'd3)
							ack_on = 1'b0;
						r.action = ACT_RX;
						r.rx_valid = 1'b1;
						r.rx_data = it.rx_byte;
						bytes_left = bytes_left - 8'd1;
						if (bytes_left == 0) begin
							r.send_stop = 1'b1;
							r.finished = 1'b1;
							done_ok = 1'b1;
							ack_on = 1'b1;
							stage = PH_IDLE;
							stops++;
						end
					end
				end
			end
			r.ack_enable = ack_on;
			r.status = done_ok;
			pending_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d: %s is %0h, should be %0h",
					results_seen, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			results_seen++;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no item waiting",
					results_seen));
				return;
			end
			want = pending_q.pop_front();
			check_field("action", got.action, want.action);
			check_field("out_byte", got.out_byte, want.out_byte);
			check_field("ack_enable", got.ack_enable, want.ack_enable);
			check_field("send_stop", got.send_stop, want.send_stop);
			check_field("tx_taken", got.tx_taken, want.tx_taken);
			check_field("rx_valid", got.rx_valid, want.rx_valid);
			check_field("rx_data", got.rx_data, want.rx_data);
			check_field("status", got.status, want.status);
			check_field("finished", got.finished, want.finished);
		endtask
	endclass

	transfer_scoreboard sb;
	bit calm = 1'b0;
	int gap_pct = 0;
	int noise_pct = 0;
	int sent = 0;
	int transfers = 0;

	function automatic item_t random_item();
		item_t it;
		it.opcode = OP_BEGIN;
		it.is_read = 1'($urandom);
		it.slave_address = 7'($urandom);
		it.register_address = 8'($urandom);
		it.register_bytes = 1'($urandom);
		it.data_bytes = 8'($urandom);
		it.tx_byte = 8'($urandom);
		it.rx_byte = 8'($urandom);
		return it;
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_item(input item_t it);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		opcode <= it.opcode;
		is_read <= it.is_read;
		slave_address <= it.slave_address;
		register_address <= it.register_address;
		register_bytes <= it.register_bytes;
		data_bytes <= it.data_bytes;
		tx_byte <= it.tx_byte;
		rx_byte <= it.rx_byte;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	// Occasionally slip a stray event in ahead of the real one.
	task automatic push_event(input item_t it);
		item_t junk;
		if ($urandom_range(0, 99) < noise_pct) begin
			junk = random_item();
			junk.opcode = 3'($urandom_range(OP_START_SENT, OP_SPARE_HI));
			send_item(junk);
		end
		send_item(it);
	endtask

	task automatic push_op(input logic [2:0] op);
		item_t it;
		it = random_item();
		it.opcode = op;
		push_event(it);
	endtask

	// One register transfer as the byte engine would report it; may be cut
	// short by a bus error or simply dropped so that the next begin aborts it.
	task automatic do_transfer(input bit rd, input bit [6:0] sa, input bit [7:0] ra,
			input bit rb, input bit [7:0] n, input int cut_pct);
		opcode_t steps[$];
		item_t it;
		int cut;
		bit cut_err;
		transfers++;
		it = random_item();
		it.opcode = OP_BEGIN;
		it.is_read = rd;
		it.slave_address = sa;
		it.register_address = ra;
		it.register_bytes = rb;
		it.data_bytes = n;
		push_event(it);
		steps.push_back(OP_START_SENT);
		steps.push_back(OP_ADDR_SENT);
		if (rb)
			steps.push_back(OP_TX_EMPTY);
		if (rd) begin
			steps.push_back(OP_TX_EMPTY);
			steps.push_back(OP_START_SENT);
			steps.push_back(OP_ADDR_SENT);
			repeat (n) steps.push_back(OP_RX_BYTE);
			// nothing left to read: this byte must be ignored
			if (n == 0)
				steps.push_back(OP_RX_BYTE);
		end else begin
			repeat (n) steps.push_back(OP_TX_EMPTY);
			steps.push_back(OP_TX_EMPTY);
		end
		cut = -1;
		if ($urandom_range(0, 99) < cut_pct)
			cut = int'($urandom_range(0, steps.size() - 1));
		cut_err = 1'($urandom);
		foreach (steps[k]) begin
			if (k == cut) begin
				if (cut_err)
					push_op(OP_BUS_ERROR);
				return;
			end
			push_op(steps[k]);
		end
	endtask

	initial begin : drive_stall
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < 12) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.action = action_t'(action);
			got.out_byte = out_byte;
			got.ack_enable = ack_enable;
			got.send_stop = send_stop;
			got.tx_taken = tx_taken;
			got.rx_valid = rx_valid;
			got.rx_data = rx_data;
			got.status = status;
			got.finished = finished;
			sb.check_result(got);
		end
	end

	initial begin : run
		int pick;
		bit [7:0] n;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: events while idle, extreme write, short read, empty read
		gap_pct = 20;
		push_op(OP_SPARE_LO);
		push_op(OP_SPARE_HI);
		push_op(OP_RX_BYTE);
		do_transfer(1'b0, 7'h7f, 8'hff, 1'b1, 8'd1, 0);
		do_transfer(1'b1, 7'h00, 8'h00, 1'b0, 8'd2, 0);
		do_transfer(1'b1, 7'h7f, 8'h00, 1'b1, 8'd0, 0);
		push_op(OP_BUS_ERROR);

		// random transfers, mostly well formed, now and then cut or noisy
		while (sent < TARGET_ITEMS) begin
			if (sent > CALM_AFTER)
				calm = 1'b1;
			pick = $urandom_range(0, 2);
			gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
			noise_pct = ($urandom_range(0, 4) == 0) ? 30 : 5;
			pick = $urandom_range(0, 99);
			// keep transfers short near the end so the total stays close
			if (pick < 85 || calm)
				n = 8'($urandom_range(0, 6));
			else if (pick < 97)
				n = 8'($urandom_range(7, 40));
			else
				n = 8'($urandom_range(41, 255));
			do_transfer(1'($urandom), 7'($urandom), 8'($urandom), 1'($urandom), n, 15);
		end
		in_valid <= 1'b0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d transfers over %0d items: %0d ended by stop, %0d by bus error.",
			transfers, sb.items_noted, sb.stops, sb.bus_errors);
		$display("Checked %0d results, %0d mismatching fields.", sb.results_seen, sb.errors);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timed out waiting for the block.");
		$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/i2crts_pkg.sv
sv/i2crts_decide.sv
sv/i2c_register_transfer_sequencer_core.sv
sv/i2crts_checker.sv
verif/tb_i2c_register_transfer_sequencer_core.sv
